FILE: src/dms_pkg.sv
// dms_pkg: types, field widths and constants for the DMS angle ALU.
// Used by dms_div, dms_norm, dms_angle_alu_top and the testbench; no dependencies.
`default_nettype none
package dms_pkg;

    localparam int FACTOR_WIDTH = 16;
    localparam int FUNC_W       = 3;
    localparam int DEG_W        = 9;
    localparam int MIN_W        = 6;
    localparam int SEC_W        = 6;
    localparam int TOT_W        = 21;

    localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CMP = 3'd4;

    localparam int SEC_PER_MIN  = 60;
    localparam int SEC_PER_DEG  = 3600;
    localparam int DEG_PER_TURN = 360;
    localparam int MIN_PER_TURN = 21600;
    localparam int SEC_PER_TURN = 1296000;

    // bias that lifts every signed total above zero
    localparam int T_BIAS = 2 * SEC_PER_TURN;
    localparam int T_W    = 31;

    // factor folded onto a positive multiple of a turn in minutes
    localparam int U_W  = FACTOR_WIDTH + 1;
    localparam int FOLD = 2 * MIN_PER_TURN;

    localparam int REM_W = 12;
    localparam int QT_W  = 11;

    // floor reciprocals, each leaves the quotient at most one short
    localparam longint R_TURN = (64'd1 << T_W) / SEC_PER_TURN;
    localparam longint R_DEG  = (64'd1 << TOT_W) / SEC_PER_DEG;
    localparam longint R_MIN  = (64'd1 << REM_W) / SEC_PER_MIN;
    localparam longint R_DEGU = (64'd1 << U_W) / DEG_PER_TURN;
    localparam longint R_MINU = (64'd1 << U_W) / MIN_PER_TURN;

    localparam int NUM_LANES  = 3;
    localparam int DIV_STAGES = 3;
    localparam int DIV_STEPS  = 3;
    localparam int NUM_W      = DIV_STAGES * DIV_STEPS;

    typedef struct packed {
        logic [FUNC_W-1:0]              func;
        logic [DEG_W-1:0]               a_degrees;
        logic [MIN_W-1:0]               a_minutes;
        logic [SEC_W-1:0]               a_seconds;
        logic [DEG_W-1:0]               b_degrees;
        logic [MIN_W-1:0]               b_minutes;
        logic [SEC_W-1:0]               b_seconds;
        logic signed [FACTOR_WIDTH-1:0] factor;
    } in_word_t;

    typedef struct packed {
        logic [DEG_W-1:0] res_degrees;
        logic [MIN_W-1:0] res_minutes;
        logic [SEC_W-1:0] res_seconds;
        logic [TOT_W-1:0] total_secs;
        logic             a_less;
        logic             a_greater;
        logic             a_equal;
        logic             div_zero;
    } out_word_t;

    typedef struct packed {
        logic less;
        logic greater;
        logic equal;
        logic div_zero;
    } flags_t;

endpackage
`default_nettype wire

FILE: src/dms_div.sv
// dms_div: pipelined restoring divider, three unsigned lanes sharing one divisor.
// Three bits of quotient per stage, each stage registered; quotients come from the last stage. Uses dms_pkg.
`default_nettype none
module dms_div (
    input  logic                                              clk,
    input  logic [dms_pkg::NUM_LANES-1:0][dms_pkg::NUM_W-1:0] dividend,
    input  logic [dms_pkg::FACTOR_WIDTH-1:0]                   divisor,
    output logic [dms_pkg::NUM_LANES-1:0][dms_pkg::NUM_W-1:0] quotient
);
    import dms_pkg::*;

    localparam int RW = FACTOR_WIDTH;

    logic [RW-1:0]    rem_reg  [DIV_STAGES][NUM_LANES];
    logic [RW-1:0]    rem_next [DIV_STAGES][NUM_LANES];
    logic [NUM_W-1:0] num_reg  [DIV_STAGES][NUM_LANES];
    logic [NUM_W-1:0] num_next [DIV_STAGES][NUM_LANES];
    logic [RW-1:0]    dvs_reg  [DIV_STAGES];
    logic [RW-1:0]    src_rem  [DIV_STAGES][NUM_LANES];
    logic [NUM_W-1:0] src_num  [DIV_STAGES][NUM_LANES];
    logic [RW-1:0]    src_dvs  [DIV_STAGES];

    always_comb
    begin
        for (int ln = 0; ln < NUM_LANES; ln++)
        begin
            src_rem[0][ln] = '0;
            src_num[0][ln] = dividend[ln];
        end
        src_dvs[0] = divisor;
        for (int st = 1; st < DIV_STAGES; st++)
        begin
            for (int ln = 0; ln < NUM_LANES; ln++)
            begin
                src_rem[st][ln] = rem_reg[st-1][ln];
                src_num[st][ln] = num_reg[st-1][ln];
            end
            src_dvs[st] = dvs_reg[st-1];
        end
    end

    always_comb
    begin
        logic [RW-1:0]    rem;
        logic [NUM_W-1:0] num;
        logic [RW:0]      sh;
        for (int st = 0; st < DIV_STAGES; st++)
        begin
            for (int ln = 0; ln < NUM_LANES; ln++)
            begin
                rem = src_rem[st][ln];
                num = src_num[st][ln];
                for (int j = 0; j < DIV_STEPS; j++)
                begin
                    sh  = {rem, num[NUM_W-1]};
                    num = {num[NUM_W-2:0], 1'b0};
                    if (sh >= {1'b0, src_dvs[st]})
                    begin
                        rem    = RW'(sh - {1'b0, src_dvs[st]});
                        num[0] = 1'b1;
                    end
                    else
                    begin
                        rem = sh[RW-1:0];
                    end
                end
                rem_next[st][ln] = rem;
                num_next[st][ln] = num;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int st = 0; st < DIV_STAGES; st++)
        begin
            dvs_reg[st] <= src_dvs[st];
            for (int ln = 0; ln < NUM_LANES; ln++)
            begin
                rem_reg[st][ln] <= rem_next[st][ln];
                num_reg[st][ln] <= num_next[st][ln];
            end
        end
    end

    always_comb
    begin
        for (int ln = 0; ln < NUM_LANES; ln++)
        begin
            quotient[ln] = num_reg[DIV_STAGES-1][ln];
        end
    end

endmodule
`default_nettype wire

FILE: src/dms_norm.sv
// dms_norm: six-stage pipeline that reduces a biased total modulo one turn, then splits
// it into degrees, minutes and seconds by reciprocal multiply. Uses dms_pkg.
`default_nettype none
module dms_norm (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  dms_pkg::flags_t           flags_in,
    input  logic [dms_pkg::T_W-1:0]   total_in,
    output logic                      valid_out,
    output dms_pkg::out_word_t        result
);
    import dms_pkg::*;

    logic [5:0]       v_reg;
    logic [5:0]       v_next;
    flags_t           fl_reg [5];
    logic [T_W-1:0]   t1_reg;
    logic [QT_W-1:0]  qt1_reg, qt1_next;
    logic [TOT_W-1:0] r2_reg, r2_next;
    logic [TOT_W-1:0] r3_reg;
    logic [9:0]       qd3_reg, qd3_next;
    logic [TOT_W-1:0] r4_reg;
    logic [DEG_W-1:0] d4_reg, d4_next;
    logic [REM_W-1:0] rem4_reg, rem4_next;
    logic [TOT_W-1:0] r5_reg;
    logic [DEG_W-1:0] d5_reg;
    logic [REM_W-1:0] rem5_reg;
    logic [6:0]       qm5_reg, qm5_next;
    out_word_t        res_reg, res_next;

    always_comb
    begin
        logic [T_W-1:0] r0;
        logic [12:0]    rem0;
        logic [6:0]     s0;
        v_next   = {v_reg[4:0], valid_in};
        qt1_next = QT_W'((42'(total_in) * 42'(R_TURN)) >> T_W);

        r0 = T_W'(t1_reg - T_W'(T_W'(qt1_reg) * T_W'(SEC_PER_TURN)));
        if (r0 >= T_W'(SEC_PER_TURN))
        begin
            r0 = T_W'(r0 - T_W'(SEC_PER_TURN));
        end
        r2_next = TOT_W'(r0);

        qd3_next = 10'((31'(r2_reg) * 31'(R_DEG)) >> TOT_W);

        rem0    = 13'(r3_reg - TOT_W'(TOT_W'(qd3_reg) * TOT_W'(SEC_PER_DEG)));
        d4_next = DEG_W'(qd3_reg);
        if (rem0 >= 13'(SEC_PER_DEG))
        begin
            rem0    = 13'(rem0 - 13'(SEC_PER_DEG));
            d4_next = DEG_W'(qd3_reg + 10'd1);
        end
        rem4_next = REM_W'(rem0);

        qm5_next = 7'((19'(rem4_reg) * 19'(R_MIN)) >> REM_W);

        s0                   = 7'(rem5_reg - REM_W'(REM_W'(qm5_reg) * REM_W'(SEC_PER_MIN)));
        res_next.res_minutes = MIN_W'(qm5_reg);
        if (s0 >= 7'(SEC_PER_MIN))
        begin
            s0                   = 7'(s0 - 7'(SEC_PER_MIN));
            res_next.res_minutes = MIN_W'(qm5_reg + 7'd1);
        end
        res_next.res_seconds = SEC_W'(s0);
        res_next.res_degrees = d5_reg;
        res_next.total_secs  = r5_reg;
        res_next.a_less      = fl_reg[4].less;
        res_next.a_greater   = fl_reg[4].greater;
        res_next.a_equal     = fl_reg[4].equal;
        res_next.div_zero    = fl_reg[4].div_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fl_reg[0] <= flags_in;
        for (int i = 1; i < 5; i++)
        begin
            fl_reg[i] <= fl_reg[i-1];
        end
        t1_reg   <= total_in;
        qt1_reg  <= qt1_next;
        r2_reg   <= r2_next;
        r3_reg   <= r2_reg;
        qd3_reg  <= qd3_next;
        r4_reg   <= r3_reg;
        d4_reg   <= d4_next;
        rem4_reg <= rem4_next;
        r5_reg   <= r4_reg;
        d5_reg   <= d4_reg;
        rem5_reg <= rem4_reg;
        qm5_reg  <= qm5_next;
        res_reg  <= res_next;
    end

    assign valid_out = v_reg[5];
    assign result    = res_reg;

endmodule
`default_nettype wire

FILE: src/dms_angle_alu_top.sv
// dms_angle_alu_top: degrees/minutes/seconds angle ALU, eleven-stage pipeline.
// Throughput: one word per cycle; busy is always low.
// The depth is set by the three-stage divider and the reciprocal modulo stages.
// Reset (rst_n, asynchronous) clears the valid bits only; no results are owed.
`default_nettype none
module dms_angle_alu_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dms_pkg::in_word_t  operands,
    output logic               done,
    output dms_pkg::out_word_t result
);
    import dms_pkg::*;

    localparam int FW = FACTOR_WIDTH;

    logic [3:0]                          v_reg;
    in_word_t                            w1_reg, w2_reg, w3_reg;
    flags_t                              fl1_reg, fl2_reg, fl3_reg, fl4_reg;
    flags_t                              fl1_next;
    logic [U_W-1:0]                      u1_reg, u2_reg;
    logic [U_W-1:0]                      u1_next;
    logic [8:0]                          q360_reg, q360_next;
    logic [2:0]                          q216_reg, q216_next;
    logic [8:0]                          f360_reg, f360_next;
    logic [14:0]                         f216_reg, f216_next;
    logic [TOT_W-1:0]                    fpos_reg, fpos_next;
    logic [17:0]                         pd_reg, pd_next;
    logic [20:0]                         pm_reg, pm_next;
    logic [26:0]                         ps_reg, ps_next;
    logic signed [10:0]                  sd_reg, sd_next;
    logic signed [10:0]                  sm_reg, sm_next;
    logic signed [10:0]                  ss_reg, ss_next;
    logic                                mul_reg;
    logic                                v5_reg;
    flags_t                              fl5_reg;
    logic [T_W-1:0]                      t5_reg, t5_next;
    logic [FW-1:0]                       fabs;
    logic [NUM_LANES-1:0][NUM_W-1:0]     dividend;
    logic [NUM_LANES-1:0][NUM_W-1:0]     quot;

    assign busy = 1'b0;

    assign fabs     = operands.factor[FW-1] ? FW'(-operands.factor) : FW'(operands.factor);
    assign dividend = {NUM_W'(operands.a_degrees), NUM_W'(operands.a_minutes),
                       NUM_W'(operands.a_seconds)};

    dms_div u_div (
        .clk      (clk),
        .dividend (dividend),
        .divisor  (fabs),
        .quotient (quot)
    );

    always_comb
    begin
        logic        eq;
        logic        lt;
        logic [16:0] r360;
        logic [16:0] r216;
        logic [9:0]  qd;
        logic [9:0]  qm;
        logic [9:0]  qs;
        // stage 1: flags and factor fold
        eq = (operands.a_degrees == operands.b_degrees) &&
             (operands.a_minutes == operands.b_minutes) &&
             (operands.a_seconds == operands.b_seconds);
        lt = (operands.a_degrees < operands.b_degrees) ||
             ((operands.a_degrees == operands.b_degrees) &&
              (operands.a_minutes < operands.b_minutes)) ||
             ((operands.a_degrees == operands.b_degrees) &&
              (operands.a_minutes == operands.b_minutes) &&
              (operands.a_seconds < operands.b_seconds));
        fl1_next.less     = lt;
        fl1_next.equal    = eq;
        fl1_next.greater  = !lt && !eq;
        fl1_next.div_zero = (operands.func == FUNC_DIV) && (operands.factor == '0);
        u1_next = U_W'(U_W'(operands.factor) + U_W'(FOLD));

        // stage 2: reciprocal quotients of the folded factor
        q360_next = 9'((27'(u1_reg) * 27'(R_DEGU)) >> U_W);
        q216_next = 3'((27'(u1_reg) * 27'(R_MINU)) >> U_W);

        // stage 3: factor modulo 360, 21600 and one turn
        r360 = U_W'(u2_reg - U_W'(U_W'(q360_reg) * U_W'(DEG_PER_TURN)));
        if (r360 >= U_W'(DEG_PER_TURN))
        begin
            r360 = U_W'(r360 - U_W'(DEG_PER_TURN));
        end
        f360_next = 9'(r360);
        r216 = U_W'(u2_reg - U_W'(U_W'(q216_reg) * U_W'(MIN_PER_TURN)));
        if (r216 >= U_W'(MIN_PER_TURN))
        begin
            r216 = U_W'(r216 - U_W'(MIN_PER_TURN));
        end
        f216_next = 15'(r216);
        fpos_next = w2_reg.factor[FW-1] ?
                    TOT_W'(32'(w2_reg.factor) + 32'(SEC_PER_TURN)) :
                    TOT_W'(w2_reg.factor);

        // stage 4: products and raw signed fields
        pd_next = 18'(18'(w3_reg.a_degrees) * 18'(f360_reg));
        pm_next = 21'(21'(w3_reg.a_minutes) * 21'(f216_reg));
        ps_next = 27'(27'(w3_reg.a_seconds) * 27'(fpos_reg));
        qd = 10'(quot[2]);
        qm = 10'(quot[1]);
        qs = 10'(quot[0]);
        case (w3_reg.func)
            FUNC_ADD:
            begin
                sd_next = $signed(11'(w3_reg.a_degrees) + 11'(w3_reg.b_degrees));
                sm_next = $signed(11'(w3_reg.a_minutes) + 11'(w3_reg.b_minutes));
                ss_next = $signed(11'(w3_reg.a_seconds) + 11'(w3_reg.b_seconds));
            end
            FUNC_SUB:
            begin
                sd_next = $signed(11'(w3_reg.a_degrees) - 11'(w3_reg.b_degrees));
                sm_next = $signed(11'(w3_reg.a_minutes) - 11'(w3_reg.b_minutes));
                ss_next = $signed(11'(w3_reg.a_seconds) - 11'(w3_reg.b_seconds));
            end
            FUNC_DIV:
            begin
                if (fl3_reg.div_zero)
                begin
                    sd_next = '0;
                    sm_next = '0;
                    ss_next = '0;
                end
                else if (w3_reg.factor[FW-1])
                begin
                    sd_next = $signed(11'(11'd0 - 11'(qd)));
                    sm_next = $signed(11'(11'd0 - 11'(qm)));
                    ss_next = $signed(11'(11'd0 - 11'(qs)));
                end
                else
                begin
                    sd_next = $signed(11'(qd));
                    sm_next = $signed(11'(qm));
                    ss_next = $signed(11'(qs));
                end
            end
            default:
            begin
                sd_next = $signed(11'(w3_reg.a_degrees));
                sm_next = $signed(11'(w3_reg.a_minutes));
                ss_next = $signed(11'(w3_reg.a_seconds));
            end
        endcase
    end

    // stage 5: total seconds, biased except for multiply
    always_comb
    begin
        logic [T_W-1:0]     t_mul;
        logic signed [31:0] t_small;
        t_mul   = T_W'(T_W'(pd_reg) * T_W'(SEC_PER_DEG)) +
                  T_W'(T_W'(pm_reg) * T_W'(SEC_PER_MIN)) + T_W'(ps_reg);
        t_small = 32'(sd_reg) * 32'(SEC_PER_DEG) + 32'(sm_reg) * 32'(SEC_PER_MIN) +
                  32'(ss_reg) + 32'(T_BIAS);
        t5_next = mul_reg ? t_mul : T_W'(t_small);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v_reg  <= {v_reg[2:0], start};
            v5_reg <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg   <= operands;
        fl1_reg  <= fl1_next;
        u1_reg   <= u1_next;
        w2_reg   <= w1_reg;
        fl2_reg  <= fl1_reg;
        u2_reg   <= u1_reg;
        q360_reg <= q360_next;
        q216_reg <= q216_next;
        w3_reg   <= w2_reg;
        fl3_reg  <= fl2_reg;
        f360_reg <= f360_next;
        f216_reg <= f216_next;
        fpos_reg <= fpos_next;
        fl4_reg  <= fl3_reg;
        pd_reg   <= pd_next;
        pm_reg   <= pm_next;
        ps_reg   <= ps_next;
        sd_reg   <= sd_next;
        sm_reg   <= sm_next;
        ss_reg   <= ss_next;
        mul_reg  <= (w3_reg.func == FUNC_MUL);
        fl5_reg  <= fl4_reg;
        t5_reg   <= t5_next;
    end

    dms_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v5_reg),
        .flags_in  (fl5_reg),
        .total_in  (t5_reg),
        .valid_out (done),
        .result    (result)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##11 done)
        else $error("result word missing eleven cycles after start");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot({result.a_less, result.a_greater, result.a_equal}))
        else $error("compare flags not one-hot");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.res_degrees < 9'd360) && (result.res_minutes < 6'd60) &&
                 (result.res_seconds < 6'd60))
        else $error("result not normalised");

    a_divzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.div_zero) |-> (result.total_secs == '0))
        else $error("divide by zero gave non-zero angle");

endmodule
`default_nettype wire

FILE: test/dms_angle_alu_top_tb.sv
// dms_angle_alu_top_tb: self-checking bench for the DMS angle ALU.
// Random and directed words go in; results are predicted and checked in order.
// Depends on dms_pkg and dms_angle_alu_top.
`timescale 1ns / 100ps

module dms_angle_alu_top_tb;
    import dms_pkg::*;

    // spare operation codes, treated as compare
    localparam logic [FUNC_W-1:0] FUNC_SPARE5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

    class angle_scoreboard;
        out_word_t pending[$];
        int        errors;
        int        checked;

        function void note_word(in_word_t w);
            longint d, m, s, f, q;
            longint ad, am, as_, bd, bm, bs;
            out_word_t r;
            ad = w.a_degrees; am = w.a_minutes; as_ = w.a_seconds;
            bd = w.b_degrees; bm = w.b_minutes; bs = w.b_seconds;
            f  = longint'(w.factor);
            r  = '0;
            case (w.func)
                FUNC_ADD: begin d = ad + bd; m = am + bm; s = as_ + bs; end
                FUNC_SUB: begin d = ad - bd; m = am - bm; s = as_ - bs; end
                FUNC_MUL: begin d = ad * f; m = am * f; s = as_ * f; end
                FUNC_DIV:
                begin
                    if (f == 0)
                    begin
                        r.div_zero = 1'b1;
                        d = 0; m = 0; s = 0;
                    end
                    else
                    begin
                        d = ad / f; m = am / f; s = as_ / f;
                    end
                end
                default: begin d = ad; m = am; s = as_; end
            endcase
            q = floor_div(s, SEC_PER_MIN); s = s - q * SEC_PER_MIN; m = m + q;
            q = floor_div(m, SEC_PER_MIN); m = m - q * SEC_PER_MIN; d = d + q;
            q = floor_div(d, DEG_PER_TURN); d = d - q * DEG_PER_TURN;
            r.res_degrees = d[DEG_W-1:0];
            r.res_minutes = m[MIN_W-1:0];
            r.res_seconds = s[SEC_W-1:0];
            r.total_secs  = TOT_W'(d * SEC_PER_DEG + m * SEC_PER_MIN + s);
            r.a_equal = (ad == bd) && (am == bm) && (as_ == bs);
            r.a_less  = (ad < bd) || (ad == bd && am < bm)
                        || (ad == bd && am == bm && as_ < bs);
            r.a_greater = !r.a_less && !r.a_equal;
            pending.push_back(r);
        endfunction

        function longint floor_div(longint v, longint dv);
            longint qq;
            qq = v / dv;
            if (v % dv < 0)
                qq = qq - 1;
            return qq;
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp_w;
            checked++;
            if (pending.size() == 0)
            begin
                report("unexpected result word", 0, got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.res_degrees != exp_w.res_degrees)
                report("res_degrees", exp_w.res_degrees, got.res_degrees);
            if (got.res_minutes != exp_w.res_minutes)
                report("res_minutes", exp_w.res_minutes, got.res_minutes);
            if (got.res_seconds != exp_w.res_seconds)
                report("res_seconds", exp_w.res_seconds, got.res_seconds);
            if (got.total_secs != exp_w.total_secs)
                report("total_secs", exp_w.total_secs, got.total_secs);
            if (got.a_less != exp_w.a_less)
                report("a_less", exp_w.a_less, got.a_less);
            if (got.a_greater != exp_w.a_greater)
                report("a_greater", exp_w.a_greater, got.a_greater);
            if (got.a_equal != exp_w.a_equal)
                report("a_equal", exp_w.a_equal, got.a_equal);
            if (got.div_zero != exp_w.div_zero)
                report("div_zero", exp_w.div_zero, got.div_zero);
        endfunction

        function void report(string what, longint exp_v, longint got_v);
            errors++;
            $display("mismatch %0d on %s: expected %0h got %0h (t=%0t)",
                     checked, what, exp_v, got_v, $time);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  operands;
    logic      done;
    out_word_t result;

    angle_scoreboard sb;
    int        sent;

    dms_angle_alu_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_word(result);

    // one word, accepted at the edge where start is seen with busy low
    task automatic send_word(in_word_t w);
        start    <= 1'b1;
        operands <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(w);
        sent++;
    endtask

    task automatic idle_gap();
        int n;
        logic [63:0] rnd;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            rnd = {$urandom, $urandom};
            start <= 1'b0;
            operands <= in_word_t'(rnd[$bits(in_word_t)-1:0]);
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic in_word_t mk(logic [FUNC_W-1:0] fn, int ad, int am, int as_,
                                    int bd, int bm, int bs, int f);
        in_word_t w;
        w.func = fn;
        w.a_degrees = DEG_W'(ad); w.a_minutes = MIN_W'(am); w.a_seconds = SEC_W'(as_);
        w.b_degrees = DEG_W'(bd); w.b_minutes = MIN_W'(bm); w.b_seconds = SEC_W'(bs);
        w.factor = FACTOR_WIDTH'(f);
        return w;
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        w = in_word_t'(rnd[$bits(in_word_t)-1:0]);
        if ($urandom_range(0, 9) != 0)
        begin
            w.func = FUNC_W'($urandom_range(0, 4));
            w.a_degrees = DEG_W'($urandom_range(0, 359));
            w.a_minutes = MIN_W'($urandom_range(0, 59));
            w.a_seconds = SEC_W'($urandom_range(0, 59));
            w.b_degrees = DEG_W'($urandom_range(0, 359));
            w.b_minutes = MIN_W'($urandom_range(0, 59));
            w.b_seconds = SEC_W'($urandom_range(0, 59));
        end
        case ($urandom_range(0, 5))
            0: w.factor = FACTOR_WIDTH'($urandom_range(0, 8) - 4);
            1: w.factor = FACTOR_WIDTH'($urandom_range(0, 200) - 100);
            2: if ($urandom_range(0, 1)) w.b_degrees = w.a_degrees;
            3:
            begin
                w.b_degrees = w.a_degrees;
                w.b_minutes = w.a_minutes;
                if ($urandom_range(0, 1)) w.b_seconds = w.a_seconds;
            end
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        sb = new();
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operands = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(mk(FUNC_ADD, 359, 59, 59, 359, 59, 59, 0));
        send_word(mk(FUNC_ADD, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk(FUNC_SUB, 0, 0, 0, 359, 59, 59, 1));
        send_word(mk(FUNC_SUB, 10, 0, 0, 0, 0, 1, 1));
        send_word(mk(FUNC_MUL, 359, 59, 59, 0, 0, 0, 32767));
        send_word(mk(FUNC_MUL, 359, 59, 59, 0, 0, 0, -32768));
        send_word(mk(FUNC_MUL, 12, 30, 45, 0, 0, 0, -1));
        send_word(mk(FUNC_DIV, 359, 59, 59, 0, 0, 0, 0));
        send_word(mk(FUNC_DIV, 359, 59, 59, 0, 0, 0, -1));
        send_word(mk(FUNC_DIV, 359, 59, 59, 0, 0, 0, 7));
        send_word(mk(FUNC_DIV, 100, 33, 17, 0, 0, 0, -32768));
        send_word(mk(FUNC_DIV, 100, 33, 17, 0, 0, 0, 32767));
        send_word(mk(FUNC_CMP, 5, 6, 7, 5, 6, 7, 0));
        send_word(mk(FUNC_CMP, 5, 6, 7, 5, 6, 8, 0));
        send_word(mk(FUNC_CMP, 5, 7, 0, 5, 6, 59, 0));
        send_word(mk(FUNC_SPARE5, 511, 63, 63, 511, 63, 63, 0));
        send_word(mk(FUNC_SPARE6, 4, 0, 0, 5, 0, 0, 3));
        send_word(mk(FUNC_SPARE7, 511, 63, 63, 0, 0, 0, -5));
        send_word(mk(FUNC_ADD, 511, 63, 63, 511, 63, 63, 0));
        send_word(mk(FUNC_SUB, 0, 0, 0, 511, 63, 63, 0));

        // drain before the random part
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);

        repeat (600)
        begin
            send_word(rand_word());
            idle_gap();
        end
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (15) @(posedge clk);

        $display("sent %0d words across all operations, %0d results checked",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("dms_angle_alu_top test passed");
        else
            $display("dms_angle_alu_top test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("dms_angle_alu_top test failed");
        $finish;
    end

endmodule
